>>> hdl/two_road_traffic_light_sequencer_macros.svh
// assertion helpers used by the checker
`ifndef TWO_ROAD_TRAFFIC_LIGHT_SEQUENCER_MACROS_SVH
`define TWO_ROAD_TRAFFIC_LIGHT_SEQUENCER_MACROS_SVH

// same-cycle implication
`define TLS_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("traffic sequencer check failed");

// next-cycle implication
`define TLS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("traffic sequencer check failed");

`endif

>>> hdl/tlseq_pkg.sv
`default_nettype none
package tlseq_pkg;

	localparam int SEC_W     = 7;
	localparam int OP_W      = 3;
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int LAMP_W    = 6;

	typedef logic [SEC_W-1:0] sec_t;

	typedef enum logic [OP_W-1:0] {
		OP_SEC_TICK  = 3'd0,
		OP_HALF_TICK = 3'd1,
		OP_INC_EDIT  = 3'd2,
		OP_CONFIRM   = 3'd3,
		OP_RESTORE   = 3'd4
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NORMAL       = 3'd0,
		MODE_BLINK_RED    = 3'd1,
		MODE_BLINK_AMBER  = 3'd2,
		MODE_BLINK_GREEN  = 3'd3,
		MODE_MANUAL_RED   = 3'd4,
		MODE_MANUAL_AMBER = 3'd5,
		MODE_MANUAL_GREEN = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		COL_RED   = 2'd0,
		COL_AMBER = 2'd1,
		COL_GREEN = 2'd2
	} colour_t;

	localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd2;

	localparam sec_t RST_RED   = 7'd5;
	localparam sec_t RST_AMBER = 7'd2;
	localparam sec_t RST_GREEN = 7'd3;
	localparam sec_t EDIT_MAX  = 7'd99;

	// road 1 red and road 2 green
	localparam logic [LAMP_W-1:0] LAMP_RESET = 6'b100_001;

	typedef struct packed {
		sec_t red;
		sec_t amber;
		sec_t green;
	} dur_t;

	typedef struct packed {
		logic [LAMP_W-1:0] lamps;
		sec_t              road1_left;
		sec_t              road2_left;
		sec_t              edit;
	} result_t;

endpackage
`default_nettype wire

>>> hdl/tlseq_if.sv
`default_nettype none
interface tlseq_evt_if;
	logic                          valid;
	logic                          ready;
	logic [tlseq_pkg::OP_W-1:0]    operation;
	logic [tlseq_pkg::MODE_W-1:0]  mode;

	modport source (output valid, output operation, output mode, input ready);
	modport sink (input valid, input operation, input mode, output ready);
endinterface

interface tlseq_res_if;
	logic                         valid;
	logic                         ready;
	logic                         road1_red_on;
	logic                         road1_amber_on;
	logic                         road1_green_on;
	logic                         road2_red_on;
	logic                         road2_amber_on;
	logic                         road2_green_on;
	logic [tlseq_pkg::SEC_W-1:0]  road1_seconds_left;
	logic [tlseq_pkg::SEC_W-1:0]  road2_seconds_left;
	logic [tlseq_pkg::SEC_W-1:0]  edit_seconds;

	modport source (
		output valid, input ready,
		output road1_red_on, output road1_amber_on, output road1_green_on,
		output road2_red_on, output road2_amber_on, output road2_green_on,
		output road1_seconds_left, output road2_seconds_left, output edit_seconds
	);
	modport sink (
		input valid, output ready,
		input road1_red_on, input road1_amber_on, input road1_green_on,
		input road2_red_on, input road2_amber_on, input road2_green_on,
		input road1_seconds_left, input road2_seconds_left, input edit_seconds
	);
endinterface
`default_nettype wire

>>> hdl/tlseq_cfg.sv
`default_nettype none
module tlseq_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [tlseq_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [tlseq_pkg::SEC_W-1:0]        cfg_data,
	output tlseq_pkg::dur_t                         dflt
);

	tlseq_pkg::dur_t dflt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q.red   <= tlseq_pkg::RST_RED;
			dflt_q.amber <= tlseq_pkg::RST_AMBER;
			dflt_q.green <= tlseq_pkg::RST_GREEN;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tlseq_pkg::CFG_RED:   dflt_q.red   <= cfg_data;
				tlseq_pkg::CFG_AMBER: dflt_q.amber <= cfg_data;
				tlseq_pkg::CFG_GREEN: dflt_q.green <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dflt = dflt_q;

endmodule
`default_nettype wire

>>> hdl/tlseq_core.sv
`default_nettype none
module tlseq_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic [tlseq_pkg::OP_W-1:0]        op,
	input  wire logic [tlseq_pkg::MODE_W-1:0]      mode,
	input  wire tlseq_pkg::dur_t                   dflt,
	output tlseq_pkg::result_t                     res
);

	typedef struct packed {
		tlseq_pkg::colour_t phase;
		tlseq_pkg::sec_t    count;
		logic [2:0]         lamp;
	} road_t;

	function automatic tlseq_pkg::sec_t dur_of(tlseq_pkg::colour_t c, tlseq_pkg::dur_t d);
		tlseq_pkg::sec_t v;
		unique case (c)
			tlseq_pkg::COL_AMBER: v = d.amber;
			tlseq_pkg::COL_GREEN: v = d.green;
			default:              v = d.red;
		endcase
		return v;
	endfunction

	// one second of one road: count down, or move to the next colour and reload
	function automatic road_t tick(tlseq_pkg::colour_t ph, tlseq_pkg::sec_t cnt,
			logic [2:0] lamp, tlseq_pkg::dur_t d);
		road_t r;
		r.phase = ph;
		r.count = cnt;
		r.lamp  = lamp;
		if (cnt > tlseq_pkg::sec_t'(1)) begin
			r.count = cnt - tlseq_pkg::sec_t'(1);
		end else begin
			unique case (ph)
				tlseq_pkg::COL_RED:   r.phase = tlseq_pkg::COL_GREEN;
				tlseq_pkg::COL_GREEN: r.phase = tlseq_pkg::COL_AMBER;
				default:              r.phase = tlseq_pkg::COL_RED;
			endcase
			r.lamp[ph]      = 1'b0;
			r.lamp[r.phase] = 1'b1;
			r.count         = dur_of(r.phase, d);
		end
		return r;
	endfunction

	tlseq_pkg::colour_t                 phase1_q, phase2_q, phase1_n, phase2_n;
	tlseq_pkg::sec_t                    count1_q, count2_q, count1_n, count2_n;
	tlseq_pkg::sec_t                    edit_q, edit_n, edit_inc;
	tlseq_pkg::dur_t                    dur_q, dur_n;
	logic [tlseq_pkg::LAMP_W-1:0]       lamp_q, lamp_n;
	road_t                              r1, r2;
	logic                               manual;

	assign r1 = tick(phase1_q, count1_q, lamp_q[2:0], dur_q);
	assign r2 = tick(phase2_q, count2_q, lamp_q[5:3], dur_q);
	assign manual = (mode == tlseq_pkg::MODE_MANUAL_RED) || (mode == tlseq_pkg::MODE_MANUAL_AMBER)
		|| (mode == tlseq_pkg::MODE_MANUAL_GREEN);
	assign edit_inc = (edit_q >= tlseq_pkg::EDIT_MAX) ? '0 : edit_q + tlseq_pkg::sec_t'(1);

	always_comb begin
		phase1_n = phase1_q;
		phase2_n = phase2_q;
		count1_n = count1_q;
		count2_n = count2_q;
		edit_n   = edit_q;
		dur_n    = dur_q;
		lamp_n   = lamp_q;
		unique case (op)
			tlseq_pkg::OP_SEC_TICK: begin
				if (mode == tlseq_pkg::MODE_NORMAL) begin
					phase1_n = r1.phase;
					count1_n = r1.count;
					phase2_n = r2.phase;
					count2_n = r2.count;
					lamp_n   = {r2.lamp, r1.lamp};
				end
			end
			tlseq_pkg::OP_HALF_TICK: begin
				unique case (mode)
					tlseq_pkg::MODE_BLINK_RED, tlseq_pkg::MODE_MANUAL_RED:
						lamp_n = lamp_q ^ 6'b001_001;
					tlseq_pkg::MODE_BLINK_AMBER, tlseq_pkg::MODE_MANUAL_AMBER:
						lamp_n = lamp_q ^ 6'b010_010;
					tlseq_pkg::MODE_BLINK_GREEN, tlseq_pkg::MODE_MANUAL_GREEN:
						lamp_n = lamp_q ^ 6'b100_100;
					default: ;
				endcase
			end
			tlseq_pkg::OP_INC_EDIT: begin
				if (manual) begin
					edit_n   = edit_inc;
					count2_n = edit_inc;
				end
			end
			tlseq_pkg::OP_CONFIRM: begin
				if (manual) begin
					count2_n = edit_q;
					unique case (mode)
						tlseq_pkg::MODE_MANUAL_RED:   dur_n.red   = edit_q;
						tlseq_pkg::MODE_MANUAL_AMBER: dur_n.amber = edit_q;
						default:                      dur_n.green = edit_q;
					endcase
				end
			end
			tlseq_pkg::OP_RESTORE: begin
				dur_n    = dflt;
				phase1_n = tlseq_pkg::COL_RED;
				phase2_n = tlseq_pkg::COL_GREEN;
				count1_n = dflt.red;
				count2_n = dflt.green;
				edit_n   = '0;
				lamp_n   = tlseq_pkg::LAMP_RESET;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase1_q     <= tlseq_pkg::COL_RED;
			phase2_q     <= tlseq_pkg::COL_GREEN;
			count1_q     <= tlseq_pkg::RST_RED;
			count2_q     <= tlseq_pkg::RST_GREEN;
			edit_q       <= '0;
			dur_q.red    <= tlseq_pkg::RST_RED;
			dur_q.amber  <= tlseq_pkg::RST_AMBER;
			dur_q.green  <= tlseq_pkg::RST_GREEN;
			lamp_q       <= tlseq_pkg::LAMP_RESET;
		end else if (en) begin
			phase1_q <= phase1_n;
			phase2_q <= phase2_n;
			count1_q <= count1_n;
			count2_q <= count2_n;
			edit_q   <= edit_n;
			dur_q    <= dur_n;
			lamp_q   <= lamp_n;
		end
	end

	assign res.lamps      = lamp_n;
	assign res.road1_left = count1_n;
	assign res.road2_left = count2_n;
	assign res.edit       = edit_n;

endmodule
`default_nettype wire

>>> hdl/two_road_traffic_light_sequencer.sv
`default_nettype none
// path: event transaction into the event register, then into the result register (result valid)
// throughput: one event per cycle while the result is not stalled; the state update is a single combinational pass
// reset: arst_n clears both stages, defaults 5/2/3 s, road 1 red, road 2 green, edit 0
// a stalled result holds in its register while one more event waits in the event register
module two_road_traffic_light_sequencer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [tlseq_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [tlseq_pkg::SEC_W-1:0]        cfg_data,
	tlseq_evt_if.sink                               evt,
	tlseq_res_if.source                             res
);

	logic                              valid_s1;
	logic [tlseq_pkg::OP_W-1:0]        op_s1;
	logic [tlseq_pkg::MODE_W-1:0]      mode_s1;
	logic                              res_valid_q;
	tlseq_pkg::result_t                res_q, res_n;
	tlseq_pkg::dur_t                   dflt;
	logic                              advance;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1   <= evt.operation;
			mode_s1 <= evt.mode;
		end
	end

	tlseq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.dflt     (dflt)
	);

	tlseq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.op     (op_s1),
		.mode   (mode_s1),
		.dflt   (dflt),
		.res    (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.road1_red_on       = res_q.lamps[0];
	assign res.road1_amber_on     = res_q.lamps[1];
	assign res.road1_green_on     = res_q.lamps[2];
	assign res.road2_red_on       = res_q.lamps[3];
	assign res.road2_amber_on     = res_q.lamps[4];
	assign res.road2_green_on     = res_q.lamps[5];
	assign res.road1_seconds_left = res_q.road1_left;
	assign res.road2_seconds_left = res_q.road2_left;
	assign res.edit_seconds       = res_q.edit;

endmodule
`default_nettype wire

>>> hdl/tlseq_checker.sv
`default_nettype none
`include "two_road_traffic_light_sequencer_macros.svh"
module tlseq_checker (
	input wire logic                                      clk,
	input wire logic                                      arst_n,
	input wire logic                                      evt_ready,
	input wire logic                                      res_valid,
	input wire logic                                      res_ready,
	input wire logic [$bits(tlseq_pkg::result_t)-1:0]     res_data,
	input wire logic [tlseq_pkg::SEC_W-1:0]               edit_seconds
);

	// a stalled result stays offered
	`TLS_ASSERT_NEXT(a_res_held, clk, arst_n, res_valid && !res_ready, res_valid)

	// and keeps its payload
	`TLS_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_data))

	// events back up only behind a stalled result
	`TLS_ASSERT_NOW(a_ready_stall, clk, arst_n, !evt_ready, res_valid && !res_ready)

	// the edit value wraps before 100
	`TLS_ASSERT_NOW(a_edit_range, clk, arst_n, res_valid, edit_seconds <= tlseq_pkg::EDIT_MAX)

endmodule

bind two_road_traffic_light_sequencer tlseq_checker u_tlseq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_ready    (evt.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_data     ({res.road2_green_on, res.road2_amber_on, res.road2_red_on,
		res.road1_green_on, res.road1_amber_on, res.road1_red_on,
		res.road1_seconds_left, res.road2_seconds_left, res.edit_seconds}),
	.edit_seconds (res.edit_seconds)
);
`default_nettype wire

>>> test/two_road_traffic_light_sequencer_tb.sv
`default_nettype none
module two_road_traffic_light_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 500_000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          PHASE_EVENTS = 100;
	localparam int          ROAD2_BASE   = 3;
	localparam int          COLOURS      = 3;

	localparam logic [tlseq_pkg::OP_W-1:0]      OP_SPARE   = 3'd7;
	localparam logic [tlseq_pkg::MODE_W-1:0]    MODE_SPARE = 3'd7;
	localparam logic [tlseq_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

	localparam tlseq_pkg::result_t AT_RESET   = '{tlseq_pkg::LAMP_RESET, tlseq_pkg::RST_RED,
		tlseq_pkg::RST_GREEN, 7'd0};
	localparam tlseq_pkg::result_t AFTER_TICK = '{tlseq_pkg::LAMP_RESET,
		tlseq_pkg::RST_RED - 7'd1, tlseq_pkg::RST_GREEN - 7'd1, 7'd0};

	typedef struct packed {
		logic [tlseq_pkg::OP_W-1:0]   op;
		logic [tlseq_pkg::MODE_W-1:0] mode;
		logic                         fixed;
		tlseq_pkg::result_t           want;
	} vector_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [tlseq_pkg::CFG_IDX_W-1:0] cfg_idx;
	tlseq_pkg::sec_t                 cfg_data;

	tlseq_evt_if evt_bus();
	tlseq_res_if res_bus();

	two_road_traffic_light_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.evt      (evt_bus.sink),
		.res      (res_bus.source)
	);

	// mirror of the controller state
	tlseq_pkg::dur_t              defaults;
	tlseq_pkg::dur_t              durations;
	tlseq_pkg::colour_t           road1_phase;
	tlseq_pkg::colour_t           road2_phase;
	tlseq_pkg::sec_t              road1_count;
	tlseq_pkg::sec_t              road2_count;
	tlseq_pkg::sec_t              edit_value;
	logic [tlseq_pkg::LAMP_W-1:0] lamps;

	tlseq_pkg::result_t lights_due[$];
	vector_t            directed [25];
	tlseq_pkg::dur_t    phase_defaults [4];
	int unsigned        mismatches;
	int unsigned        cycle_count;
	int                 stall_left;
	bit                 calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic tlseq_pkg::sec_t phase_length(tlseq_pkg::colour_t c);
		case (c)
			tlseq_pkg::COL_AMBER: return durations.amber;
			tlseq_pkg::COL_GREEN: return durations.green;
			default:              return durations.red;
		endcase
	endfunction

	function automatic void advance_road(inout tlseq_pkg::colour_t phase,
			inout tlseq_pkg::sec_t count, input int base);
		tlseq_pkg::colour_t nxt;
		if (count > 1) begin
			count = tlseq_pkg::sec_t'(count - 1);
			return;
		end
		case (phase)
			tlseq_pkg::COL_RED:   nxt = tlseq_pkg::COL_GREEN;
			tlseq_pkg::COL_GREEN: nxt = tlseq_pkg::COL_AMBER;
			default:              nxt = tlseq_pkg::COL_RED;
		endcase
		lamps[base + int'(phase)] = 1'b0;
		lamps[base + int'(nxt)]   = 1'b1;
		phase = nxt;
		count = phase_length(nxt);
	endfunction

	function automatic void restore_lights();
		durations   = defaults;
		road1_phase = tlseq_pkg::COL_RED;
		road2_phase = tlseq_pkg::COL_GREEN;
		road1_count = durations.red;
		road2_count = durations.green;
		edit_value  = '0;
		lamps       = tlseq_pkg::LAMP_RESET;
	endfunction

	function automatic tlseq_pkg::result_t light_event(logic [tlseq_pkg::OP_W-1:0] op,
			logic [tlseq_pkg::MODE_W-1:0] mode);
		int colour;
		bit manual;
		manual = (mode >= tlseq_pkg::MODE_MANUAL_RED) && (mode <= tlseq_pkg::MODE_MANUAL_GREEN);
		case (op)
			tlseq_pkg::OP_SEC_TICK: begin
				if (mode == tlseq_pkg::MODE_NORMAL) begin
					advance_road(road1_phase, road1_count, 0);
					advance_road(road2_phase, road2_count, ROAD2_BASE);
				end
			end
			tlseq_pkg::OP_HALF_TICK: begin
				if (mode >= tlseq_pkg::MODE_BLINK_RED && mode <= tlseq_pkg::MODE_MANUAL_GREEN) begin
					colour = (int'(mode) - 1) % COLOURS;
					lamps[colour]              = ~lamps[colour];
					lamps[ROAD2_BASE + colour] = ~lamps[ROAD2_BASE + colour];
				end
			end
			tlseq_pkg::OP_INC_EDIT: begin
				if (manual) begin
					edit_value  = (edit_value >= tlseq_pkg::EDIT_MAX) ? tlseq_pkg::sec_t'(0) :
						tlseq_pkg::sec_t'(edit_value + 1);
					road2_count = edit_value;
				end
			end
			tlseq_pkg::OP_CONFIRM: begin
				if (manual) begin
					case (mode)
						tlseq_pkg::MODE_MANUAL_RED:   durations.red   = edit_value;
						tlseq_pkg::MODE_MANUAL_AMBER: durations.amber = edit_value;
						default:                      durations.green = edit_value;
					endcase
					road2_count = edit_value;
				end
			end
			tlseq_pkg::OP_RESTORE: restore_lights();
			default: ;
		endcase
		return '{lamps, road1_count, road2_count, edit_value};
	endfunction

	function automatic int idle_span();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_result();
		tlseq_pkg::result_t want;
		tlseq_pkg::result_t got;
		got = {res_bus.road2_green_on, res_bus.road2_amber_on, res_bus.road2_red_on,
			res_bus.road1_green_on, res_bus.road1_amber_on, res_bus.road1_red_on,
			res_bus.road1_seconds_left, res_bus.road2_seconds_left, res_bus.edit_seconds};
		if (lights_due.size() == 0) begin
			$error("result transaction with no event pending");
			mismatches++;
			return;
		end
		want = lights_due.pop_front();
		check_field("road1_red_on", want.lamps[0], got.lamps[0]);
		check_field("road1_amber_on", want.lamps[1], got.lamps[1]);
		check_field("road1_green_on", want.lamps[2], got.lamps[2]);
		check_field("road2_red_on", want.lamps[3], got.lamps[3]);
		check_field("road2_amber_on", want.lamps[4], got.lamps[4]);
		check_field("road2_green_on", want.lamps[5], got.lamps[5]);
		check_field("road1_seconds_left", want.road1_left, got.road1_left);
		check_field("road2_seconds_left", want.road2_left, got.road2_left);
		check_field("edit_seconds", want.edit, got.edit);
	endfunction

	task automatic send_event(logic [tlseq_pkg::OP_W-1:0] op, logic [tlseq_pkg::MODE_W-1:0] mode,
			bit fixed = 1'b0, tlseq_pkg::result_t want = '0);
		tlseq_pkg::result_t predicted;
		int                 gap;
		evt_bus.valid     <= 1'b1;
		evt_bus.operation <= op;
		evt_bus.mode      <= mode;
		@(posedge clk);
		while (!evt_bus.ready)
			@(posedge clk);
		predicted = light_event(op, mode);
		lights_due.push_back(fixed ? want : predicted);
		gap = idle_span();
		if (gap > 0) begin
			evt_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		evt_bus.valid <= 1'b0;
		@(posedge clk);
		while (lights_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_default(logic [tlseq_pkg::CFG_IDX_W-1:0] idx, tlseq_pkg::sec_t value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			tlseq_pkg::CFG_RED:   defaults.red   = value;
			tlseq_pkg::CFG_AMBER: defaults.amber = value;
			tlseq_pkg::CFG_GREEN: defaults.green = value;
			default: ;
		endcase
	endtask

	task automatic set_defaults(tlseq_pkg::dur_t d);
		program_default(CFG_SPARE, tlseq_pkg::sec_t'($urandom()));
		program_default(tlseq_pkg::CFG_RED, d.red);
		program_default(tlseq_pkg::CFG_AMBER, d.amber);
		program_default(tlseq_pkg::CFG_GREEN, d.green);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int budget);
		int                           sent;
		int                           k;
		int                           kind;
		logic [tlseq_pkg::MODE_W-1:0] m;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 9);
			calm = ($urandom_range(0, 4) == 0);
			if (kind <= 3) begin
				// normal sequencing
				k = $urandom_range(1, 25);
				repeat (k)
					send_event(($urandom_range(0, 15) == 0) ? tlseq_pkg::OP_HALF_TICK :
						tlseq_pkg::OP_SEC_TICK, tlseq_pkg::MODE_NORMAL);
				sent += k;
			end else if (kind <= 5) begin
				m = tlseq_pkg::MODE_W'($urandom_range(tlseq_pkg::MODE_BLINK_RED,
					tlseq_pkg::MODE_MANUAL_GREEN));
				k = $urandom_range(1, 8);
				repeat (k)
					send_event(($urandom_range(0, 7) == 0) ? tlseq_pkg::OP_SEC_TICK :
						tlseq_pkg::OP_HALF_TICK, m);
				sent += k;
			end else if (kind <= 7) begin
				// edit then confirm, now and then long enough to wrap
				m = tlseq_pkg::MODE_W'($urandom_range(tlseq_pkg::MODE_MANUAL_RED,
					tlseq_pkg::MODE_MANUAL_GREEN));
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(90, 110) : $urandom_range(0, 6);
				repeat (k)
					send_event(tlseq_pkg::OP_INC_EDIT, m);
				send_event(tlseq_pkg::OP_CONFIRM, m);
				sent += k + 1;
			end else if (kind == 8) begin
				send_event(tlseq_pkg::OP_RESTORE,
					tlseq_pkg::MODE_W'($urandom_range(tlseq_pkg::MODE_NORMAL, MODE_SPARE)));
				sent += 1;
			end else begin
				k = $urandom_range(1, 6);
				repeat (k)
					send_event(tlseq_pkg::OP_W'($urandom_range(tlseq_pkg::OP_SEC_TICK, OP_SPARE)),
						tlseq_pkg::MODE_W'($urandom_range(tlseq_pkg::MODE_NORMAL, MODE_SPARE)));
				sent += k;
			end
		end
	endtask

	// result side with random stalls
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready)
				check_result();
			if (stall_left > 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
				stall_left = idle_span();
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = tlseq_pkg::CFG_RED;
		cfg_data          = '0;
		evt_bus.valid     = 1'b0;
		evt_bus.operation = tlseq_pkg::OP_SEC_TICK;
		evt_bus.mode      = tlseq_pkg::MODE_NORMAL;
		res_bus.ready     = 1'b0;
		calm              = 1'b0;
		mismatches        = 0;
		stall_left        = 0;
		defaults          = '{tlseq_pkg::RST_RED, tlseq_pkg::RST_AMBER, tlseq_pkg::RST_GREEN};
		restore_lights();

		directed = '{
			'{tlseq_pkg::OP_HALF_TICK, tlseq_pkg::MODE_NORMAL,       1'b1, AT_RESET},
			'{tlseq_pkg::OP_SEC_TICK,  tlseq_pkg::MODE_BLINK_AMBER,  1'b1, AT_RESET},
			'{tlseq_pkg::OP_INC_EDIT,  tlseq_pkg::MODE_BLINK_RED,    1'b1, AT_RESET},
			'{tlseq_pkg::OP_CONFIRM,   tlseq_pkg::MODE_NORMAL,       1'b1, AT_RESET},
			'{OP_SPARE,                tlseq_pkg::MODE_MANUAL_GREEN, 1'b1, AT_RESET},
			'{tlseq_pkg::OP_INC_EDIT,  MODE_SPARE,                   1'b1, AT_RESET},
			'{tlseq_pkg::OP_HALF_TICK, MODE_SPARE,                   1'b1, AT_RESET},
			'{tlseq_pkg::OP_SEC_TICK,  tlseq_pkg::MODE_NORMAL,       1'b1, AFTER_TICK},
			'{tlseq_pkg::OP_HALF_TICK, tlseq_pkg::MODE_BLINK_RED,    1'b0, '0},
			'{tlseq_pkg::OP_HALF_TICK, tlseq_pkg::MODE_BLINK_AMBER,  1'b0, '0},
			'{tlseq_pkg::OP_HALF_TICK, tlseq_pkg::MODE_BLINK_GREEN,  1'b0, '0},
			'{tlseq_pkg::OP_HALF_TICK, tlseq_pkg::MODE_MANUAL_RED,   1'b0, '0},
			'{tlseq_pkg::OP_SEC_TICK,  tlseq_pkg::MODE_NORMAL,       1'b0, '0},
			'{tlseq_pkg::OP_SEC_TICK,  tlseq_pkg::MODE_NORMAL,       1'b0, '0},
			'{tlseq_pkg::OP_SEC_TICK,  tlseq_pkg::MODE_NORMAL,       1'b0, '0},
			'{tlseq_pkg::OP_SEC_TICK,  tlseq_pkg::MODE_NORMAL,       1'b0, '0},
			'{tlseq_pkg::OP_INC_EDIT,  tlseq_pkg::MODE_MANUAL_AMBER, 1'b0, '0},
			'{tlseq_pkg::OP_CONFIRM,   tlseq_pkg::MODE_MANUAL_AMBER, 1'b0, '0},
			'{tlseq_pkg::OP_RESTORE,   tlseq_pkg::MODE_NORMAL,       1'b1, AT_RESET},
			'{tlseq_pkg::OP_CONFIRM,   tlseq_pkg::MODE_MANUAL_GREEN, 1'b0, '0},
			'{tlseq_pkg::OP_CONFIRM,   tlseq_pkg::MODE_MANUAL_RED,   1'b0, '0},
			'{tlseq_pkg::OP_SEC_TICK,  tlseq_pkg::MODE_NORMAL,       1'b0, '0},
			'{tlseq_pkg::OP_SEC_TICK,  tlseq_pkg::MODE_NORMAL,       1'b0, '0},
			'{tlseq_pkg::OP_HALF_TICK, tlseq_pkg::MODE_MANUAL_GREEN, 1'b0, '0},
			'{tlseq_pkg::OP_RESTORE,   MODE_SPARE,                   1'b1, AT_RESET}
		};

		phase_defaults[0] = '{7'd1, 7'd1, 7'd1};
		phase_defaults[1] = '{tlseq_pkg::EDIT_MAX, tlseq_pkg::EDIT_MAX, tlseq_pkg::EDIT_MAX};
		phase_defaults[2] = '{7'd0, 7'd127, 7'd0};
		phase_defaults[3] = '{tlseq_pkg::sec_t'($urandom_range(1, 99)),
			tlseq_pkg::sec_t'($urandom_range(1, 99)), tlseq_pkg::sec_t'($urandom_range(1, 99))};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_event(directed[i].op, directed[i].mode, directed[i].fixed, directed[i].want);
		random_phase(PHASE_EVENTS);

		foreach (phase_defaults[p]) begin
			drain();
			calm = 1'b0;
			set_defaults(phase_defaults[p]);
			send_event(tlseq_pkg::OP_RESTORE, tlseq_pkg::MODE_NORMAL);
			random_phase(PHASE_EVENTS);
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && lights_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
